// ===== hw/rtl/ctpp_pkg.sv =====
// ============================================================================
// ctpp_pkg
// shared types and constants of the chainage to polyline point block
// ============================================================================
package ctpp_pkg;

    localparam int DEF_MAX_SECTIONS = 64;
    localparam int DIV_W            = 64;
    localparam int DVS_W            = 33;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_WR  = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // write: w0 start, w1 end, w2..w4 vertex
    // query: w0 chainage, w1 offset, w2 height
    typedef struct packed {
        logic        op;
        logic [6:0]  index;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] w4;
    } t_item;

endpackage

// ===== hw/rtl/ctpp_ram.sv =====
// ============================================================================
// ctpp_ram
// generic single write port ram with registered read
// ============================================================================
module ctpp_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ctpp_div.sv =====
// ============================================================================
// ctpp_div
// unsigned restoring divider, one quotient bit per cycle
// ============================================================================
module ctpp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ctpp_pkg::DIV_W-1:0]  i_dividend,
    input  logic [ctpp_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [ctpp_pkg::DIV_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(ctpp_pkg::DIV_W);

    logic                       r_busy;
    logic [CNT_W-1:0]           r_cnt;
    logic [ctpp_pkg::DVS_W-1:0] r_rem;
    logic [ctpp_pkg::DVS_W-1:0] r_dvs;
    logic [ctpp_pkg::DIV_W-1:0] r_quo;
    logic [ctpp_pkg::DVS_W:0]   sh;
    logic                       ge;

    assign sh = {r_rem, r_quo[ctpp_pkg::DIV_W-1]};
    assign ge = (sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ctpp_pkg::DIV_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? ctpp_pkg::DVS_W'(sh - {1'b0, r_dvs}) : sh[ctpp_pkg::DVS_W-1:0];
            r_quo <= {r_quo[ctpp_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/ctpp_front.sv =====
// ============================================================================
// ctpp_front
// accepts items, packs them by kind and queues them for the back end
// ============================================================================
module ctpp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_op,
    input  logic [6:0]          i_entry_index,
    input  logic [31:0]         i_section_start,
    input  logic [31:0]         i_section_end,
    input  logic [31:0]         i_vertex_x,
    input  logic [31:0]         i_vertex_y,
    input  logic [31:0]         i_vertex_z,
    input  logic [31:0]         i_query_chainage,
    input  logic [31:0]         i_query_offset,
    input  logic [31:0]         i_query_height,
    output logic                o_busy,
    output logic                o_valid,
    output ctpp_pkg::t_item     o_item,
    input  logic                i_pop
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    ctpp_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    ctpp_pkg::t_item item;
    logic            push;

    always_comb begin
        item       = '0;
        item.op    = i_op;
        item.index = i_entry_index;
        if (i_op == ctpp_pkg::OP_WRITE) begin
            item.w0 = i_section_start;
            item.w1 = i_section_end;
            item.w2 = i_vertex_x;
            item.w3 = i_vertex_y;
            item.w4 = i_vertex_z;
        end else begin
            item.w0 = i_query_chainage;
            item.w1 = i_query_offset;
            item.w2 = i_query_height;
        end
    end

    assign o_busy  = (r_cnt == (PW+1)'(DEPTH));
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= item;
        end
    end

endmodule

// ===== hw/rtl/ctpp_back.sv =====
// ============================================================================
// ctpp_back
// table store, section search and point computation sequencer
// ============================================================================
module ctpp_back #(
    parameter int MAX_SECTIONS = ctpp_pkg::DEF_MAX_SECTIONS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [6:0]          i_section_count,
    input  logic                i_q_valid,
    input  ctpp_pkg::t_item     i_q_item,
    output logic                o_q_pop,
    output logic                o_done,
    output logic [31:0]         o_out_x,
    output logic [31:0]         o_out_y,
    output logic [31:0]         o_out_z,
    output logic [5:0]          o_section_used,
    output logic [1:0]          o_status
);

    localparam int SW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int VW = $clog2(MAX_SECTIONS + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_CMP  = 5'd2;
    localparam logic [4:0] S_LD0  = 5'd3;
    localparam logic [4:0] S_LD1  = 5'd4;
    localparam logic [4:0] S_LD2  = 5'd5;
    localparam logic [4:0] S_CHK  = 5'd6;
    localparam logic [4:0] S_SQX  = 5'd7;
    localparam logic [4:0] S_SQY  = 5'd8;
    localparam logic [4:0] S_SQZ  = 5'd9;
    localparam logic [4:0] S_SQA  = 5'd10;
    localparam logic [4:0] S_SQRT = 5'd11;
    localparam logic [4:0] S_WRT  = 5'd12;
    localparam logic [4:0] S_MX   = 5'd13;
    localparam logic [4:0] S_MY   = 5'd14;
    localparam logic [4:0] S_MOX  = 5'd15;
    localparam logic [4:0] S_DOX  = 5'd16;
    localparam logic [4:0] S_WOX  = 5'd17;
    localparam logic [4:0] S_MOY  = 5'd18;
    localparam logic [4:0] S_DOY  = 5'd19;
    localparam logic [4:0] S_WOY  = 5'd20;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > SAT_HI) begin
            r = 32'h7fff_ffff;
        end else if (v < SAT_LO) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // control
    logic [4:0]         r_state;
    logic [SW:0]        r_idx;
    logic [SW:0]        r_n;
    logic [SW-1:0]      r_sec;
    logic               r_done;

    // payload
    logic signed [31:0] r_q, r_off, r_h;
    logic signed [31:0] r_start, r_end, r_v1x, r_v1y, r_v1z;
    logic signed [32:0] r_dx, r_dy, r_dz, r_num, r_den;
    logic [30:0]        r_sx, r_sy, r_sz;
    logic               r_sxn, r_syn;
    logic [63:0]        r_acc, r_rem, r_root, r_bit;
    logic [31:0]        r_len;
    logic [31:0]        r_rate;
    logic               r_rate_neg;
    logic signed [49:0] r_cx, r_cy;
    logic [64:0]        r_prod;
    logic [31:0]        r_x, r_y, r_z;
    logic [5:0]         r_used;
    logic [1:0]         r_status;

    // memories
    logic               sec_we, vtx_we;
    logic [SW-1:0]      sec_waddr, sec_raddr;
    logic [VW-1:0]      vtx_waddr, vtx_raddr;
    logic [31:0]        start_rd, end_rd, vx_rd, vy_rd, vz_rd;

    // shared units
    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic               div_start, div_busy;
    logic [63:0]        div_dvd, div_quo;
    logic [32:0]        div_dvs;
    logic [SW:0]        sec_limit;
    logic [64:0]        sq_t;
    logic [32:0]        mdx, mdy, mdz, mnum, mden;
    logic               shr;
    logic [63:0]        sq_sum;
    logic [49:0]        p50;
    logic signed [63:0] ofs;
    logic               rate_sgn;
    logic [31:0]        rate_mag;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        if (int'(i_section_count) > MAX_SECTIONS) begin
            sec_limit = (SW+1)'(MAX_SECTIONS);
        end else begin
            sec_limit = (SW+1)'(i_section_count);
        end
    end

    assign sec_we    = o_q_pop && (i_q_item.op == ctpp_pkg::OP_WRITE)
                       && (int'(i_q_item.index) < MAX_SECTIONS);
    assign vtx_we    = o_q_pop && (i_q_item.op == ctpp_pkg::OP_WRITE)
                       && (int'(i_q_item.index) <= MAX_SECTIONS);
    assign sec_waddr = SW'(i_q_item.index);
    assign vtx_waddr = VW'(i_q_item.index);
    assign sec_raddr = (r_state == S_RD) ? r_idx[SW-1:0] : r_sec;
    assign vtx_raddr = (r_state == S_LD1) ? VW'(r_sec) + VW'(1) : VW'(r_sec);

    ctpp_ram #(.W(32), .D(MAX_SECTIONS)) u_start_ram (
        .i_clk(i_clk), .i_we(sec_we), .i_waddr(sec_waddr), .i_wdata(i_q_item.w0),
        .i_raddr(sec_raddr), .o_rdata(start_rd)
    );
    ctpp_ram #(.W(32), .D(MAX_SECTIONS)) u_end_ram (
        .i_clk(i_clk), .i_we(sec_we), .i_waddr(sec_waddr), .i_wdata(i_q_item.w1),
        .i_raddr(sec_raddr), .o_rdata(end_rd)
    );
    ctpp_ram #(.W(32), .D(MAX_SECTIONS + 1)) u_vx_ram (
        .i_clk(i_clk), .i_we(vtx_we), .i_waddr(vtx_waddr), .i_wdata(i_q_item.w2),
        .i_raddr(vtx_raddr), .o_rdata(vx_rd)
    );
    ctpp_ram #(.W(32), .D(MAX_SECTIONS + 1)) u_vy_ram (
        .i_clk(i_clk), .i_we(vtx_we), .i_waddr(vtx_waddr), .i_wdata(i_q_item.w3),
        .i_raddr(vtx_raddr), .o_rdata(vy_rd)
    );
    ctpp_ram #(.W(32), .D(MAX_SECTIONS + 1)) u_vz_ram (
        .i_clk(i_clk), .i_we(vtx_we), .i_waddr(vtx_waddr), .i_wdata(i_q_item.w4),
        .i_raddr(vtx_raddr), .o_rdata(vz_rd)
    );

    // divider operands
    assign mnum = mag33(r_num);
    assign mden = mag33(r_den);
    assign div_start = (r_state == S_CHK && r_den != '0
                        && (r_dx != '0 || r_dy != '0 || r_dz != '0))
                       || (r_state == S_DOX) || (r_state == S_DOY);
    assign div_dvd = (r_state == S_CHK) ? {15'd0, mnum, 16'd0} : r_prod[63:0];
    assign div_dvs = (r_state == S_CHK) ? mden : {1'b0, r_len};

    ctpp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(div_dvd), .i_divisor(div_dvs),
        .o_busy(div_busy), .o_quotient(div_quo)
    );

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = 33'(r_sx);
                mul_b = 32'(r_sx);
            end
            S_SQY: begin
                mul_a = 33'(r_sy);
                mul_b = 32'(r_sy);
            end
            S_SQZ: begin
                mul_a = 33'(r_sz);
                mul_b = 32'(r_sz);
            end
            S_MX: begin
                mul_a = mag33(r_dx);
                mul_b = r_rate;
            end
            S_MY: begin
                mul_a = mag33(r_dy);
                mul_b = r_rate;
            end
            S_MOX: begin
                mul_a = mag33(33'(r_off));
                mul_b = 32'(r_sy);
            end
            S_MOY: begin
                mul_a = mag33(33'(r_off));
                mul_b = 32'(r_sx);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign mdx    = mag33(r_dx);
    assign mdy    = mag33(r_dy);
    assign mdz    = mag33(r_dz);
    assign shr    = mdx[32] | mdx[31] | mdy[32] | mdy[31] | mdz[32] | mdz[31];
    assign sq_sum = r_acc + r_prod[63:0];
    assign sq_t   = {1'b0, r_root} + {1'b0, r_bit};
    assign p50    = {1'b0, r_prod[64:16]};
    assign ofs    = ((r_off[31] ^ ((r_state == S_WOX) ? r_syn : r_sxn))
                     ? -$signed(div_quo) : $signed(div_quo));

    // rate saturation
    assign rate_sgn = r_num[32] ^ r_den[32];
    always_comb begin
        if (rate_sgn) begin
            rate_mag = (div_quo > 64'd2147483648) ? 32'h8000_0000 : div_quo[31:0];
        end else begin
            rate_mag = (div_quo > 64'd2147483647) ? 32'h7fff_ffff : div_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_idx   <= '0;
            r_n     <= '0;
            r_sec   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_item.op == ctpp_pkg::OP_WRITE) begin
                            r_done <= 1'b1;
                        end else if (sec_limit == '0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_n     <= sec_limit;
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= S_CMP;
                S_CMP: begin
                    if ($signed(end_rd) > r_q || r_idx == (SW+1)'(r_n - 1'b1)) begin
                        r_sec   <= r_idx[SW-1:0];
                        r_state <= S_LD0;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_LD0: r_state <= S_LD1;
                S_LD1: r_state <= S_LD2;
                S_LD2: r_state <= S_CHK;
                S_CHK: begin
                    if (div_start) begin
                        r_state <= S_SQX;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: r_state <= S_SQZ;
                S_SQZ: r_state <= S_SQA;
                S_SQA: r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_state <= S_WRT;
                    end
                end
                S_WRT: begin
                    if (!div_busy) begin
                        r_state <= S_MX;
                    end
                end
                S_MX:  r_state <= S_MY;
                S_MY:  r_state <= S_MOX;
                S_MOX: r_state <= S_DOX;
                S_DOX: r_state <= S_WOX;
                S_WOX: begin
                    if (!div_busy) begin
                        r_state <= S_MOY;
                    end
                end
                S_MOY: r_state <= S_DOY;
                S_DOY: r_state <= S_WOY;
                S_WOY: begin
                    if (!div_busy) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q      <= i_q_item.w0;
                r_off    <= i_q_item.w1;
                r_h      <= i_q_item.w2;
                r_x      <= '0;
                r_y      <= '0;
                r_z      <= '0;
                r_used   <= '0;
                r_status <= (i_q_item.op == ctpp_pkg::OP_WRITE) ? ctpp_pkg::ST_WR
                                                                : ctpp_pkg::ST_ERR;
            end
            S_LD1: begin
                r_start <= start_rd;
                r_end   <= end_rd;
                r_v1x   <= vx_rd;
                r_v1y   <= vy_rd;
                r_v1z   <= vz_rd;
            end
            S_LD2: begin
                r_dx  <= 33'($signed(vx_rd)) - 33'(r_v1x);
                r_dy  <= 33'($signed(vy_rd)) - 33'(r_v1y);
                r_dz  <= 33'($signed(vz_rd)) - 33'(r_v1z);
                r_den <= 33'(r_end) - 33'(r_start);
                r_num <= 33'(r_q) - 33'(r_start);
            end
            S_CHK: begin
                r_sx     <= shr ? mdx[31:1] : mdx[30:0];
                r_sy     <= shr ? mdy[31:1] : mdy[30:0];
                r_sz     <= shr ? mdz[31:1] : mdz[30:0];
                r_sxn    <= r_dx[32];
                r_syn    <= r_dy[32];
                r_used   <= 6'(r_sec);
                r_status <= ctpp_pkg::ST_ERR;
            end
            S_SQY: r_acc <= r_prod[63:0];
            S_SQZ: r_acc <= sq_sum;
            S_SQA: begin
                r_rem  <= sq_sum;
                r_root <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end
            S_SQRT: begin
                if (r_bit == '0) begin
                    r_len <= r_root[31:0];
                end else begin
                    if ({1'b0, r_rem} >= sq_t) begin
                        r_rem  <= 64'({1'b0, r_rem} - sq_t);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            S_WRT: begin
                r_rate     <= rate_mag;
                r_rate_neg <= rate_sgn && (rate_mag != '0);
            end
            S_MY: begin
                r_cx <= (r_dx[32] ^ r_rate_neg) ? 50'(r_v1x) - $signed(p50)
                                                : 50'(r_v1x) + $signed(p50);
            end
            S_MOX: begin
                r_cy <= (r_dy[32] ^ r_rate_neg) ? 50'(r_v1y) - $signed(p50)
                                                : 50'(r_v1y) + $signed(p50);
            end
            S_WOX: begin
                r_x <= sat32(66'(r_cx) + 66'(ofs));
            end
            S_WOY: begin
                r_y      <= sat32(66'(r_cy) - 66'(ofs));
                r_z      <= r_h;
                r_status <= ctpp_pkg::ST_OK;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_out_x        = r_x;
    assign o_out_y        = r_y;
    assign o_out_z        = r_z;
    assign o_section_used = r_used;
    assign o_status       = r_status;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ctpp_pkg::ST_ERR)
            |-> (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("error result with nonzero coordinates");

    a_search_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |=> (r_state == S_RD || r_state == S_LD0))
        else $error("section search left its loop");

    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ctpp_pkg::ST_WR) |-> $past(o_q_pop))
        else $error("write acknowledge without a popped item");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

// ===== hw/rtl/chainage_to_polyline_point.sv =====
// ============================================================================
// chainage_to_polyline_point
// maps route chainage, offset and height to a 3d point on a stored polyline
// ============================================================================
// items enter on start while busy is low; one transfer per accepted item
// op write stores a section's chainages and a vertex, op query maps a point
// items go into a two-entry queue; busy is high only while it is full
// each item gives one result, shown for one cycle with o_done high;
// the receiver cannot stall, so results are never held
// a write's o_done is driven from the sequencer's done register, set once
// the item has passed the queue and been popped by the idle sequencer
// a query searches the sections one at a time, reads the table entries,
// then runs the rate division with the squares and the root overlapped,
// then two more divisions for the offset on the same bit-serial divider
// the back end pops the next item only once the current one is done
// the section count register is written on the cfg channel (always ready)
// and must only change while the block is idle
// reset clears the queue and sequencer and sets the section count to 1;
// the tables are undefined until written
// ============================================================================
module chainage_to_polyline_point #(
    parameter int MAX_SECTIONS = ctpp_pkg::DEF_MAX_SECTIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [6:0]  i_entry_index,
    input  logic [31:0] i_section_start,
    input  logic [31:0] i_section_end,
    input  logic [31:0] i_vertex_x,
    input  logic [31:0] i_vertex_y,
    input  logic [31:0] i_vertex_z,
    input  logic [31:0] i_query_chainage,
    input  logic [31:0] i_query_offset,
    input  logic [31:0] i_query_height,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_z,
    output logic [5:0]  o_section_used,
    output logic [1:0]  o_status
);

    logic [6:0]      r_section_count;
    logic            q_valid;
    logic            q_pop;
    ctpp_pkg::t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= 7'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_section_count <= i_cfg_data;
        end
    end

    ctpp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_op(i_op), .i_entry_index(i_entry_index),
        .i_section_start(i_section_start), .i_section_end(i_section_end),
        .i_vertex_x(i_vertex_x), .i_vertex_y(i_vertex_y), .i_vertex_z(i_vertex_z),
        .i_query_chainage(i_query_chainage), .i_query_offset(i_query_offset),
        .i_query_height(i_query_height),
        .o_busy(busy), .o_valid(q_valid), .o_item(q_item), .i_pop(q_pop)
    );

    ctpp_back #(.MAX_SECTIONS(MAX_SECTIONS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_section_count(r_section_count),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_done(o_done), .o_out_x(o_out_x), .o_out_y(o_out_y), .o_out_z(o_out_z),
        .o_section_used(o_section_used), .o_status(o_status)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top
// testbench of the chainage to polyline point block
// ============================================================================
// table writes and point queries go in on the start/busy handshake, and every
// result is checked against a predictor that keeps its own copy of the tables
// and of the section count; the count is changed only while the block is idle
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        op;
        logic [6:0]  index;
        int          sec_start;
        int          sec_end;
        int          vx;
        int          vy;
        int          vz;
        int          chainage;
        int          offset;
        int          height;
    } t_request;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  used;
        logic [1:0]  status;
    } t_point;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_op;
    logic [6:0]  i_entry_index;
    logic [31:0] i_section_start;
    logic [31:0] i_section_end;
    logic [31:0] i_vertex_x;
    logic [31:0] i_vertex_y;
    logic [31:0] i_vertex_z;
    logic [31:0] i_query_chainage;
    logic [31:0] i_query_offset;
    logic [31:0] i_query_height;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        o_done;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic [5:0]  o_section_used;
    logic [1:0]  o_status;

    longint start_tab [ctpp_pkg::DEF_MAX_SECTIONS];
    longint end_tab   [ctpp_pkg::DEF_MAX_SECTIONS];
    longint vx_tab    [ctpp_pkg::DEF_MAX_SECTIONS + 1];
    longint vy_tab    [ctpp_pkg::DEF_MAX_SECTIONS + 1];
    longint vz_tab    [ctpp_pkg::DEF_MAX_SECTIONS + 1];
    int     section_count;
    t_point point_queue [$];
    int     error_count;
    int     quiet_cycles;
    bit     pauses_on;

    chainage_to_polyline_point u_top (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint unsigned mag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned rem, root, bitpos;
        rem = v;
        root = 0;
        bitpos = 64'd1 << 62;
        while (bitpos > v) bitpos >>= 2;
        while (bitpos != 0) begin
            if (rem >= root + bitpos) begin
                rem -= root + bitpos;
                root = (root >> 1) + bitpos;
            end else begin
                root >>= 1;
            end
            bitpos >>= 2;
        end
        return root;
    endfunction

    function automatic longint lerp_axis(longint v1, longint d, longint rate);
        longint unsigned prod;
        prod = (mag(d) * mag(rate)) >> 16;
        return ((d < 0) != (rate < 0)) ? v1 - longint'(prod) : v1 + longint'(prod);
    endfunction

    function automatic longint shr_mag(longint v, int s);
        longint m;
        m = longint'(mag(v) >> s);
        return v < 0 ? -m : m;
    endfunction

    function automatic t_point predict_point(t_request r);
        t_point p;
        longint q, off, dx, dy, dz, den, num, rate, cx, cy, sx, sy, sz, len;
        longint unsigned m;
        int n, sec, s, idx;
        p = '{default: '0};
        if (r.op == ctpp_pkg::OP_WRITE) begin
            idx = int'(r.index);
            if (idx < ctpp_pkg::DEF_MAX_SECTIONS) begin
                start_tab[idx] = r.sec_start;
                end_tab[idx] = r.sec_end;
            end
            if (idx <= ctpp_pkg::DEF_MAX_SECTIONS) begin
                vx_tab[idx] = r.vx;
                vy_tab[idx] = r.vy;
                vz_tab[idx] = r.vz;
            end
            p.status = ctpp_pkg::ST_WR;
            return p;
        end
        n = section_count > ctpp_pkg::DEF_MAX_SECTIONS ? ctpp_pkg::DEF_MAX_SECTIONS
                                                        : section_count;
        if (n == 0) begin
            p.status = ctpp_pkg::ST_ERR;
            return p;
        end
        q = r.chainage;
        off = r.offset;
        sec = n - 1;
        for (int i = 0; i < n; i++) begin
            if (end_tab[i] > q) begin
                sec = i;
                break;
            end
        end
        p.used = sec[5:0];
        dx = vx_tab[sec + 1] - vx_tab[sec];
        dy = vy_tab[sec + 1] - vy_tab[sec];
        dz = vz_tab[sec + 1] - vz_tab[sec];
        den = end_tab[sec] - start_tab[sec];
        if (den == 0 || (dx == 0 && dy == 0 && dz == 0)) begin
            p.status = ctpp_pkg::ST_ERR;
            return p;
        end
        num = q - start_tab[sec];
        rate = sat32((num * 65536) / den);
        cx = lerp_axis(vx_tab[sec], dx, rate);
        cy = lerp_axis(vy_tab[sec], dy, rate);
        m = mag(dx);
        if (mag(dy) > m) m = mag(dy);
        if (mag(dz) > m) m = mag(dz);
        s = 0;
        while ((m >> s) >= 64'h8000_0000) s++;
        sx = shr_mag(dx, s);
        sy = shr_mag(dy, s);
        sz = shr_mag(dz, s);
        len = longint'(int_sqrt(longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz)));
        p.x = 32'(sat32(cx + (off * sy) / len));
        p.y = 32'(sat32(cy + ((off * sx) / len) * -1));
        p.z = r.height;
        p.status = ctpp_pkg::ST_OK;
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_done) begin
            if (point_queue.size() == 0) begin
                $display("mismatch: result with no transfer outstanding");
                error_count++;
            end else begin
                want = point_queue.pop_front();
                if (o_out_x !== want.x) report_mismatch("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report_mismatch("out_y", o_out_y, want.y);
                if (o_out_z !== want.z) report_mismatch("out_z", o_out_z, want.z);
                if (o_section_used !== want.used)
                    report_mismatch("section_used", 32'(o_section_used), 32'(want.used));
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL chainage_to_polyline_point");
            $finish;
        end
    end

    task automatic maybe_pause();
        if (pauses_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
    endtask

    task automatic send_item(t_request r);
        maybe_pause();
        @(negedge i_clk);
        start = 1'b1;
        i_op = r.op;
        i_entry_index = r.index;
        i_section_start = r.sec_start;
        i_section_end = r.sec_end;
        i_vertex_x = r.vx;
        i_vertex_y = r.vy;
        i_vertex_z = r.vz;
        i_query_chainage = r.chainage;
        i_query_offset = r.offset;
        i_query_height = r.height;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        point_queue = {point_queue, predict_point(r)};
    endtask

    function automatic t_request noise_request();
        t_request r;
        r.op = 1'($urandom_range(0, 1));
        r.index = 7'($urandom_range(0, 127));
        r.sec_start = $urandom;
        r.sec_end = $urandom;
        r.vx = $urandom;
        r.vy = $urandom;
        r.vz = $urandom;
        r.chainage = $urandom;
        r.offset = $urandom;
        r.height = $urandom;
        return r;
    endfunction

    task automatic write_entry(int idx, int s0, int s1, int x, int y, int z);
        t_request r;
        r = noise_request();
        r.op = ctpp_pkg::OP_WRITE;
        r.index = 7'(idx);
        r.sec_start = s0;
        r.sec_end = s1;
        r.vx = x;
        r.vy = y;
        r.vz = z;
        send_item(r);
    endtask

    task automatic query_point(int c, int off, int h);
        t_request r;
        r = noise_request();
        r.op = ctpp_pkg::OP_QUERY;
        r.chainage = c;
        r.offset = off;
        r.height = h;
        send_item(r);
    endtask

    task automatic set_section_count(int value);
        @(negedge i_clk);
        start = 1'b0;
        while (point_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = 7'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        section_count = value & 7'h7f;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // whole route: n sections from chainage c0, mostly well formed
    task automatic build_route(int n, int c0);
        int c, len, x, y, z, wide;
        c = c0;
        wide = $urandom_range(0, 7) == 0;
        x = $urandom;
        y = $urandom;
        z = $urandom;
        for (int i = 0; i <= n; i++) begin
            len = $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 1 << 16);
            if (i > 0 && $urandom_range(0, 15) != 0) begin
                if (wide) begin
                    x = $urandom;
                    y = $urandom;
                    z = $urandom;
                end else begin
                    x += $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                    y += $signed($urandom_range(0, 1 << 21)) - (1 << 20);
                    z += $signed($urandom_range(0, 1 << 13)) - (1 << 12);
                end
            end
            write_entry(i, c, c + len, x, y, z);
            c += len;
        end
    endtask

    task automatic test_reset_count();
        for (int i = 0; i <= ctpp_pkg::DEF_MAX_SECTIONS; i++)
            write_entry(i, i * 256, i * 256 + 256, i * 1000, i * 300, i * 7);
        query_point(128, 512, 77);
        query_point(2000, -512, -77);
    endtask

    task automatic test_extremes();
        write_entry(0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                    32'sh8000_0000);
        write_entry(1, 0, 1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        set_section_count(1);
        query_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        query_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000);
        query_point(0, 0, 0);
        query_point(-1, -1, -1);
    endtask

    task automatic test_degenerate();
        write_entry(0, 500, 500, 0, 0, 0);
        write_entry(1, 500, 900, 10, 20, 30);
        query_point(100, 256, 5);
        write_entry(0, 0, 400, 10, 20, 30);
        query_point(100, 256, 5);
        write_entry(0, 0, 400, 0, 0, 0);
        query_point(100, 256, 5);
    endtask

    task automatic test_count_limits();
        write_entry(127, 1, 2, 3, 4, 5);
        write_entry(65, 1, 2, 3, 4, 5);
        write_entry(64, 9, 9, 4096, -4096, 256);
        set_section_count(0);
        query_point(0, 0, 0);
        set_section_count(64);
        query_point(32'sh7fff_ffff, 1000, 1);
        set_section_count(127);
        query_point(32'sh7fff_ffff, -1000, 2);
        set_section_count(100);
        query_point(20000, 0, 3);
    endtask

    task automatic test_random_routes(int routes);
        int n, c0, span;
        t_request r;
        for (int k = 0; k < routes; k++) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(9, 64) : $urandom_range(1, 8);
            c0 = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
            build_route(n, c0);
            set_section_count($urandom_range(0, 15) == 0 ? $urandom_range(0, 127) : n);
            span = n * 65536;
            repeat ($urandom_range(25, 45)) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = noise_request();
                    if (r.op == ctpp_pkg::OP_WRITE && r.index <= ctpp_pkg::DEF_MAX_SECTIONS)
                        r.index = 7'(65 + int'(r.index) % 63);
                    send_item(r);
                end else begin
                    query_point(c0 - 32768 + $signed($urandom_range(0, span + 65536)),
                                $urandom_range(0, 3) == 0 ? $urandom
                                    : $signed($urandom_range(0, 1 << 17)) - (1 << 16),
                                $urandom);
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_op = ctpp_pkg::OP_WRITE;
        i_entry_index = '0;
        i_section_start = '0;
        i_section_end = '0;
        i_vertex_x = '0;
        i_vertex_y = '0;
        i_vertex_z = '0;
        i_query_chainage = '0;
        i_query_offset = '0;
        i_query_height = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        section_count = 1;
        error_count = 0;
        quiet_cycles = 0;
        pauses_on = 1'b1;
        foreach (start_tab[i]) begin
            start_tab[i] = 0;
            end_tab[i] = 0;
        end
        foreach (vx_tab[i]) begin
            vx_tab[i] = 0;
            vy_tab[i] = 0;
            vz_tab[i] = 0;
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_count();
        test_extremes();
        test_degenerate();
        test_count_limits();
        test_random_routes(25);
        pauses_on = 1'b0;
        test_random_routes(6);

        @(negedge i_clk);
        start = 1'b0;
        while (point_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS chainage_to_polyline_point");
        else
            $display("FAIL chainage_to_polyline_point");
        $finish;
    end

endmodule
